// ===== rtl/qs_pkg.sv =====
// ----------------------------------------------------------------------------
// qs_pkg : shared types and constants for the quaternion slerp pipeline
// Widths, CORDIC arctangent table, stage counts and the sideband record that
// travels beside the arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

package qs_pkg;

  localparam int THR_W = 15;
  localparam logic [THR_W-1:0] THR_RESET = 15'd32765;

  localparam int CORDIC_N = 28;
  localparam int ISQ_N    = 31;
  localparam int DIV_N    = 32;
  localparam int LANE_LAT = CORDIC_N + DIV_N;

  localparam logic signed [32:0] INV_GAIN = 33'sd652032874;

  // atan(2^-i) in Q.30 radians
  localparam logic signed [32:0] ATAN_Q30 [CORDIC_N] = '{
    33'sd843314857, 33'sd497837829, 33'sd263043837, 33'sd133525159,
    33'sd67021687,  33'sd33543516,  33'sd16775851,  33'sd8388437,
    33'sd4194283,   33'sd2097149,   33'sd1048576,   33'sd524288,
    33'sd262144,    33'sd131072,    33'sd65536,     33'sd32768,
    33'sd16384,     33'sd8192,      33'sd4096,      33'sd2048,
    33'sd1024,      33'sd512,       33'sd256,       33'sd128,
    33'sd64,        33'sd32,        33'sd16,        33'sd8
  };

  typedef struct packed {
    logic             v;
    logic             pass_a;
    logic             pass_b;
    logic             neg;
    logic             linear;
    logic [14:0]      cosq;
    logic [16:0]      t;
    logic [3:0][15:0] a;
    logic [3:0][16:0] b;
    logic [30:0]      s30;
  } side_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic signed [15:0] w;
    logic [14:0]        cos_omega;
    logic               cos_valid;
    logic               b_negated;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/qs_if.sv =====
// ----------------------------------------------------------------------------
// qs_if : request channels of the quaternion slerp block
// Input channel carries two quaternions and the blend factor; output channel
// carries the blended quaternion and status.
// ----------------------------------------------------------------------------
`default_nettype none

interface qs_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] a_x;
  logic signed [15:0] a_y;
  logic signed [15:0] a_z;
  logic signed [15:0] a_w;
  logic signed [15:0] b_x;
  logic signed [15:0] b_y;
  logic signed [15:0] b_z;
  logic signed [15:0] b_w;
  logic signed [17:0] blend;

  modport source (output valid, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, blend,
                  input ready);
  modport sink   (input valid, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, blend,
                  output ready);
endinterface

interface qs_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic signed [15:0] out_z;
  logic signed [15:0] out_w;
  logic [14:0]        cos_omega;
  logic               cos_valid;
  logic               b_negated;

  modport source (output valid, out_x, out_y, out_z, out_w, cos_omega, cos_valid,
                  b_negated, input ready);
  modport sink   (input valid, out_x, out_y, out_z, out_w, cos_omega, cos_valid,
                  b_negated, output ready);
endinterface

`default_nettype wire

// ===== rtl/qs_isqrt.sv =====
// ----------------------------------------------------------------------------
// qs_isqrt : pipelined integer square root
// One result bit per stage, remainder method, floor of the root of a 61-bit
// radicand. Sideband record travels alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module qs_isqrt (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic [60:0]   rad,
  input  qs_pkg::side_t side_in,
  output logic [30:0]   root,
  output qs_pkg::side_t side_out
);
  import qs_pkg::*;

  logic [61:0] rem    [ISQ_N];
  logic [61:0] res    [ISQ_N];
  side_t       sd     [ISQ_N];
  logic [61:0] rem_p  [ISQ_N];
  logic [61:0] res_p  [ISQ_N];
  side_t       sd_p   [ISQ_N];
  logic [61:0] rem_nx [ISQ_N];
  logic [61:0] res_nx [ISQ_N];
  logic [61:0] bitv;
  logic [61:0] trial;

  always_comb begin
    rem_p[0] = {1'b0, rad};
    res_p[0] = '0;
    sd_p[0]  = side_in;
    for (int g = 1; g < ISQ_N; g++) begin
      rem_p[g] = rem[g-1];
      res_p[g] = res[g-1];
      sd_p[g]  = sd[g-1];
    end
    bitv  = '0;
    trial = '0;
    for (int g = 0; g < ISQ_N; g++) begin
      bitv  = 62'd1 << (2 * (ISQ_N - 1 - g));
      trial = res_p[g] + bitv;
      if (rem_p[g] >= trial) begin
        rem_nx[g] = rem_p[g] - trial;
        res_nx[g] = (res_p[g] >> 1) + bitv;
      end else begin
        rem_nx[g] = rem_p[g];
        res_nx[g] = res_p[g] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < ISQ_N; g++) sd[g].v <= 1'b0;
    end else if (en) begin
      rem <= rem_nx;
      res <= res_nx;
      sd  <= sd_p;
    end
  end

  assign root     = res[ISQ_N-1][30:0];
  assign side_out = sd[ISQ_N-1];

endmodule

`default_nettype wire

// ===== rtl/qs_cordic_vec.sv =====
// ----------------------------------------------------------------------------
// qs_cordic_vec : pipelined CORDIC in vectoring mode
// Drives y towards zero and accumulates the angle of (x, y) in Q.30 radians.
// ----------------------------------------------------------------------------
`default_nettype none

module qs_cordic_vec (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic signed [32:0]  x_in,
  input  logic signed [32:0]  y_in,
  input  qs_pkg::side_t       side_in,
  output logic signed [32:0]  angle,
  output qs_pkg::side_t       side_out
);
  import qs_pkg::*;

  logic signed [32:0] x    [CORDIC_N];
  logic signed [32:0] y    [CORDIC_N];
  logic signed [32:0] z    [CORDIC_N];
  side_t              sd   [CORDIC_N];
  logic signed [32:0] x_p  [CORDIC_N];
  logic signed [32:0] y_p  [CORDIC_N];
  logic signed [32:0] z_p  [CORDIC_N];
  side_t              sd_p [CORDIC_N];
  logic signed [32:0] x_nx [CORDIC_N];
  logic signed [32:0] y_nx [CORDIC_N];
  logic signed [32:0] z_nx [CORDIC_N];

  always_comb begin
    x_p[0]  = x_in;
    y_p[0]  = y_in;
    z_p[0]  = '0;
    sd_p[0] = side_in;
    for (int g = 1; g < CORDIC_N; g++) begin
      x_p[g]  = x[g-1];
      y_p[g]  = y[g-1];
      z_p[g]  = z[g-1];
      sd_p[g] = sd[g-1];
    end
    for (int g = 0; g < CORDIC_N; g++) begin
      if (!y_p[g][32]) begin
        x_nx[g] = x_p[g] + (y_p[g] >>> g);
        y_nx[g] = y_p[g] - (x_p[g] >>> g);
        z_nx[g] = z_p[g] + ATAN_Q30[g];
      end else begin
        x_nx[g] = x_p[g] - (y_p[g] >>> g);
        y_nx[g] = y_p[g] + (x_p[g] >>> g);
        z_nx[g] = z_p[g] - ATAN_Q30[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < CORDIC_N; g++) sd[g].v <= 1'b0;
    end else if (en) begin
      x  <= x_nx;
      y  <= y_nx;
      z  <= z_nx;
      sd <= sd_p;
    end
  end

  assign angle    = z[CORDIC_N-1];
  assign side_out = sd[CORDIC_N-1];

endmodule

`default_nettype wire

// ===== rtl/qs_weight_lane.sv =====
// ----------------------------------------------------------------------------
// qs_weight_lane : one interpolation weight
// CORDIC rotation gives the sine of the sub-angle, then a restoring divider
// forms sine * 2^30 / sin(omega), one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qs_weight_lane (
  input  logic               clk,
  input  logic               en,
  input  logic signed [32:0] ang,
  input  logic [30:0]        dvs,
  output logic [31:0]        q,
  output logic               qneg
);
  import qs_pkg::*;

  // rotation section
  logic signed [32:0] cx    [CORDIC_N];
  logic signed [32:0] cy    [CORDIC_N];
  logic signed [32:0] cz    [CORDIC_N];
  logic [30:0]        cd    [CORDIC_N];
  logic signed [32:0] cx_p  [CORDIC_N];
  logic signed [32:0] cy_p  [CORDIC_N];
  logic signed [32:0] cz_p  [CORDIC_N];
  logic [30:0]        cd_p  [CORDIC_N];
  logic signed [32:0] cx_nx [CORDIC_N];
  logic signed [32:0] cy_nx [CORDIC_N];
  logic signed [32:0] cz_nx [CORDIC_N];

  // divider section
  logic [62:0] dr    [DIV_N];
  logic [31:0] dq    [DIV_N];
  logic [30:0] dd    [DIV_N];
  logic        ds    [DIV_N];
  logic [62:0] dr_p  [DIV_N];
  logic [31:0] dq_p  [DIV_N];
  logic [30:0] dd_p  [DIV_N];
  logic        ds_p  [DIV_N];
  logic [62:0] dr_nx [DIV_N];
  logic [31:0] dq_nx [DIV_N];
  logic signed [32:0] sine;
  logic [32:0]        mag;
  logic [62:0]        dsh;

  always_comb begin
    cx_p[0] = INV_GAIN;
    cy_p[0] = '0;
    cz_p[0] = ang;
    cd_p[0] = dvs;
    for (int g = 1; g < CORDIC_N; g++) begin
      cx_p[g] = cx[g-1];
      cy_p[g] = cy[g-1];
      cz_p[g] = cz[g-1];
      cd_p[g] = cd[g-1];
    end
    for (int g = 0; g < CORDIC_N; g++) begin
      if (!cz_p[g][32]) begin
        cx_nx[g] = cx_p[g] - (cy_p[g] >>> g);
        cy_nx[g] = cy_p[g] + (cx_p[g] >>> g);
        cz_nx[g] = cz_p[g] - ATAN_Q30[g];
      end else begin
        cx_nx[g] = cx_p[g] + (cy_p[g] >>> g);
        cy_nx[g] = cy_p[g] - (cx_p[g] >>> g);
        cz_nx[g] = cz_p[g] + ATAN_Q30[g];
      end
    end
  end

  always_comb begin
    sine = cy[CORDIC_N-1];
    mag  = sine[32] ? 33'(-sine) : 33'(sine);
    dr_p[0] = {1'b0, mag[31:0], 30'b0};
    dq_p[0] = '0;
    dd_p[0] = cd[CORDIC_N-1];
    ds_p[0] = sine[32];
    for (int g = 1; g < DIV_N; g++) begin
      dr_p[g] = dr[g-1];
      dq_p[g] = dq[g-1];
      dd_p[g] = dd[g-1];
      ds_p[g] = ds[g-1];
    end
    dsh = '0;
    for (int g = 0; g < DIV_N; g++) begin
      dsh      = {32'b0, dd_p[g]} << (DIV_N - 1 - g);
      dq_nx[g] = dq_p[g];
      if (dr_p[g] >= dsh) begin
        dr_nx[g] = dr_p[g] - dsh;
        dq_nx[g][DIV_N-1-g] = 1'b1;
      end else begin
        dr_nx[g] = dr_p[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx <= cx_nx;
      cy <= cy_nx;
      cz <= cz_nx;
      cd <= cd_p;
      dr <= dr_nx;
      dq <= dq_nx;
      dd <= dd_p;
      ds <= ds_p;
    end
  end

  assign q    = dq[DIV_N-1];
  assign qneg = ds[DIV_N-1];

endmodule

`default_nettype wire

// ===== rtl/qs_blend_lane.sv =====
// ----------------------------------------------------------------------------
// qs_blend_lane : one output component
// Registers k0*a and k1*b, then rounds, shifts down by 30 and saturates.
// ----------------------------------------------------------------------------
`default_nettype none

module qs_blend_lane (
  input  logic               clk,
  input  logic               en,
  input  logic signed [32:0] k0,
  input  logic signed [32:0] k1,
  input  logic signed [15:0] a,
  input  logic signed [16:0] b,
  output logic signed [15:0] y
);
  localparam logic signed [50:0] HALF = 51'sd536870912;

  logic signed [48:0] p0;
  logic signed [49:0] p1;
  logic signed [50:0] sum;
  logic signed [50:0] shd;

  always_ff @(posedge clk) begin
    if (en) begin
      p0 <= k0 * a;
      p1 <= k1 * b;
    end
  end

  always_comb begin
    sum = 51'(p0) + 51'(p1) + HALF;
    shd = sum >>> 30;
    if (shd > 51'sd32767)       y = 16'sh7fff;
    else if (shd < -51'sd32768) y = -16'sh8000;
    else                        y = shd[15:0];
  end

endmodule

`default_nettype wire

// ===== rtl/quaternion_slerp.sv =====
// ----------------------------------------------------------------------------
// quaternion_slerp : fixed-point spherical linear interpolation of quaternions
// Dot product, square root, vectoring CORDIC for the angle, two weight lanes
// (rotation CORDIC and divider) and four blend lanes, fully pipelined.
//
//   channel    dir  handshake        contents
//   slerp_in   in   valid / ready    a_x..a_w, b_x..b_w, blend
//   slerp_out  out  valid / ready    out_x..out_w, cos_omega, cos_valid, b_negated
//   cfg        in   cfg_we           linear_threshold (cfg_data)
//
// One request per cycle while ready is high; a result passes through the 31-stage
// root, the 28-stage vectoring and rotation CORDICs and the 32-stage divider. A result
// waiting at the output parks in a skid register while the pipeline keeps moving;
// ready drops only once that skid register is full.
// Reset clears all valid bits and loads the threshold with 32765.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_slerp (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [qs_pkg::THR_W-1:0] cfg_data,
  qs_in_if.sink                    slerp_in,
  qs_out_if.source                 slerp_out
);
  import qs_pkg::*;

  logic            en;
  logic [THR_W-1:0] thr;

  logic               s1_v;
  logic signed [15:0] s1_a [4];
  logic signed [15:0] s1_b [4];
  logic signed [17:0] s1_t;

  logic               s2_v;
  logic signed [31:0] s2_p [4];
  logic signed [15:0] s2_a [4];
  logic signed [15:0] s2_b [4];
  logic signed [17:0] s2_t;

  logic               s3_v;
  logic signed [33:0] s3_dot;
  logic signed [15:0] s3_a [4];
  logic signed [15:0] s3_b [4];
  logic signed [17:0] s3_t;

  side_t       side4_nx;
  side_t       side4;
  side_t       side5;
  side_t       side6;
  logic [33:0] absd;
  logic [18:0] cqf;
  logic        dneg;
  logic signed [16:0] bx;
  logic [29:0] s5_sq;
  logic [60:0] s6_rad;

  logic [30:0] isq_root;
  side_t       isq_side;
  side_t       vec_side_in;
  logic signed [32:0] vec_x;
  logic signed [32:0] vec_y;
  logic signed [32:0] vec_z;
  side_t       vec_side;

  logic [30:0] w;
  logic [16:0] tm;
  logic [47:0] sw_p0;
  logic [47:0] sw_p1;
  side_t       side_w;

  side_t       side_l [LANE_LAT];
  logic [31:0] q0;
  logic [31:0] q1;
  logic        qn0;
  logic        qn1;

  side_t       side_l_end;
  logic [16:0] tm_k;
  logic signed [32:0] k0_nx;
  logic signed [32:0] k1_nx;
  logic signed [32:0] k0;
  logic signed [32:0] k1;
  side_t       side_k;
  side_t       side_p;
  logic signed [15:0] lane_y [4];

  res_t fin;
  logic fin_v;
  logic take;
  res_t o;
  logic ov;
  res_t s;
  logic sv;

  assign en             = !sv;
  assign slerp_in.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg_we) begin
      thr <= cfg_data;
    end
  end

  // accept
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else if (en) begin
      s1_v <= slerp_in.valid;
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_a[0] <= slerp_in.a_x;
      s1_a[1] <= slerp_in.a_y;
      s1_a[2] <= slerp_in.a_z;
      s1_a[3] <= slerp_in.a_w;
      s1_b[0] <= slerp_in.b_x;
      s1_b[1] <= slerp_in.b_y;
      s1_b[2] <= slerp_in.b_z;
      s1_b[3] <= slerp_in.b_w;
      s1_t    <= slerp_in.blend;
      for (int j = 0; j < 4; j++) begin
        s2_p[j] <= s1_a[j] * s1_b[j];
      end
      s2_a   <= s1_a;
      s2_b   <= s1_b;
      s2_t   <= s1_t;
      s3_dot <= 34'(s2_p[0]) + 34'(s2_p[1]) + 34'(s2_p[2]) + 34'(s2_p[3]);
      s3_a   <= s2_a;
      s3_b   <= s2_b;
      s3_t   <= s2_t;
    end
  end

  // shortest path, cosine and branch choice
  always_comb begin
    side4_nx        = '0;
    side4_nx.v      = s3_v;
    side4_nx.pass_a = s3_t[17] || (s3_t == '0);
    side4_nx.pass_b = !s3_t[17] && s3_t[16];
    dneg            = s3_dot[33];
    side4_nx.neg    = dneg && !side4_nx.pass_a && !side4_nx.pass_b;
    absd            = dneg ? 34'(-s3_dot) : 34'(s3_dot);
    cqf             = absd[33:15];
    side4_nx.cosq   = (cqf > 19'd32767) ? 15'h7fff : cqf[14:0];
    side4_nx.linear = side4_nx.cosq > thr;
    side4_nx.t      = s3_t[16:0];
    bx              = '0;
    for (int j = 0; j < 4; j++) begin
      side4_nx.a[j] = s3_a[j];
      bx            = 17'(s3_b[j]);
      side4_nx.b[j] = side4_nx.neg ? 17'(-bx) : bx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side4.v <= 1'b0;
      side5.v <= 1'b0;
      side6.v <= 1'b0;
    end else if (en) begin
      side4  <= side4_nx;
      side5  <= side4;
      s5_sq  <= 30'(side4.cosq) * 30'(side4.cosq);
      side6  <= side5;
      s6_rad <= {1'b1, 60'b0} - {1'b0, s5_sq, 30'b0};
    end
  end

  qs_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .rad      (s6_rad),
    .side_in  (side6),
    .root     (isq_root),
    .side_out (isq_side)
  );

  always_comb begin
    vec_side_in     = isq_side;
    vec_side_in.s30 = isq_root;
    vec_x           = {3'b0, isq_side.cosq, 15'b0};
    vec_y           = {2'b0, isq_root};
  end

  qs_cordic_vec u_vec (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .x_in     (vec_x),
    .y_in     (vec_y),
    .side_in  (vec_side_in),
    .angle    (vec_z),
    .side_out (vec_side)
  );

  // sub-angles w*(1-t) and w*t
  assign w  = vec_z[32] ? '0 : vec_z[30:0];
  assign tm = 17'h10000 - vec_side.t;

  always_ff @(posedge clk) begin
    if (rst) begin
      side_w.v <= 1'b0;
    end else if (en) begin
      sw_p0  <= 48'(w) * 48'(tm);
      sw_p1  <= 48'(w) * 48'(vec_side.t);
      side_w <= vec_side;
    end
  end

  qs_weight_lane u_wl0 (
    .clk  (clk),
    .en   (en),
    .ang  ({1'b0, sw_p0[47:16]}),
    .dvs  (side_w.s30),
    .q    (q0),
    .qneg (qn0)
  );

  qs_weight_lane u_wl1 (
    .clk  (clk),
    .en   (en),
    .ang  ({1'b0, sw_p1[47:16]}),
    .dvs  (side_w.s30),
    .q    (q1),
    .qneg (qn1)
  );

  // sideband rides beside the weight lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < LANE_LAT; g++) side_l[g].v <= 1'b0;
    end else if (en) begin
      side_l[0] <= side_w;
      for (int g = 1; g < LANE_LAT; g++) side_l[g] <= side_l[g-1];
    end
  end

  // weight select: linear or spherical
  always_comb begin
    side_l_end = side_l[LANE_LAT-1];
    tm_k       = 17'h10000 - side_l_end.t;
    if (side_l_end.linear) begin
      k0_nx = {2'b0, tm_k, 14'b0};
      k1_nx = {2'b0, side_l_end.t, 14'b0};
    end else begin
      k0_nx = qn0 ? -{1'b0, q0} : {1'b0, q0};
      k1_nx = qn1 ? -{1'b0, q1} : {1'b0, q1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_k.v <= 1'b0;
      side_p.v <= 1'b0;
    end else if (en) begin
      k0     <= k0_nx;
      k1     <= k1_nx;
      side_k <= side_l_end;
      side_p <= side_k;
    end
  end

  for (genvar j = 0; j < 4; j++) begin : g_blend
    qs_blend_lane u_bl (
      .clk (clk),
      .en  (en),
      .k0  (k0),
      .k1  (k1),
      .a   ($signed(side_k.a[j])),
      .b   ($signed(side_k.b[j])),
      .y   (lane_y[j])
    );
  end

  // merge lanes, handle the end points of t
  always_comb begin
    fin = '0;
    if (side_p.pass_a) begin
      fin.x = $signed(side_p.a[0]);
      fin.y = $signed(side_p.a[1]);
      fin.z = $signed(side_p.a[2]);
      fin.w = $signed(side_p.a[3]);
    end else if (side_p.pass_b) begin
      fin.x = $signed(side_p.b[0][15:0]);
      fin.y = $signed(side_p.b[1][15:0]);
      fin.z = $signed(side_p.b[2][15:0]);
      fin.w = $signed(side_p.b[3][15:0]);
    end else begin
      fin.x         = lane_y[0];
      fin.y         = lane_y[1];
      fin.z         = lane_y[2];
      fin.w         = lane_y[3];
      fin.cos_omega = side_p.cosq;
      fin.cos_valid = 1'b1;
      fin.b_negated = side_p.neg;
    end
  end

  assign fin_v = en && side_p.v;
  assign take  = slerp_out.ready || !ov;

  // output register with skid
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (take) begin
      if (sv) begin
        ov <= 1'b1;
        sv <= 1'b0;
      end else begin
        ov <= fin_v;
      end
    end else if (fin_v) begin
      sv <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      o <= sv ? s : fin;
    end else if (fin_v) begin
      s <= fin;
    end
  end

  assign slerp_out.valid     = ov;
  assign slerp_out.out_x     = o.x;
  assign slerp_out.out_y     = o.y;
  assign slerp_out.out_z     = o.z;
  assign slerp_out.out_w     = o.w;
  assign slerp_out.cos_omega = o.cos_omega;
  assign slerp_out.cos_valid = o.cos_valid;
  assign slerp_out.b_negated = o.b_negated;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top : self-checking bench for the quaternion slerp pipeline
// Offers quaternion pairs with blend factors on the request channel and
// predicts every result with a fixed-point slerp model held in the bench.
// Each result is compared field by field with the oldest prediction. The run
// covers directed corner cases, several threshold settings, random traffic
// with idle bursts on both sides, and a long output stall that fills the pipe.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import qs_pkg::*;

  localparam int           LIMIT_CYCLES = 400000;
  localparam int           DRAIN_CYCLES = 200;
  localparam int           STALL_CYCLES = 400;
  localparam longint       CORDIC_K     = 652032874;
  localparam longint       ONE_T        = 65536;

  typedef struct {
    logic signed [15:0] a [4];
    logic signed [15:0] b [4];
    logic signed [17:0] blend;
  } slerp_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [THR_W-1:0] cfg_data = '0;

  qs_in_if  in_ch ();
  qs_out_if out_ch ();

  quaternion_slerp i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .slerp_in  (in_ch),
    .slerp_out (out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic [THR_W-1:0] threshold = THR_RESET;
  res_t   blend_q [$];
  int     errors = 0;
  int     cycles = 0;
  int     sent = 0;
  int     checked = 0;
  int     linear_hits = 0;
  int     flips = 0;
  int     cfg_writes = 0;
  bit     idle_en = 1'b0;
  bit     stall_on = 1'b0;
  int     hold_req = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.a_x = '0; in_ch.a_y = '0; in_ch.a_z = '0; in_ch.a_w = '0;
    in_ch.b_x = '0; in_ch.b_y = '0; in_ch.b_z = '0; in_ch.b_w = '0;
    in_ch.blend = '0;
    out_ch.ready = 1'b0;
  end

  // ---------------- predictor ----------------
  function automatic longint atan_q30(int i);
    longint tab [12] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                         33543516, 16775851, 8388437, 4194283, 2097149,
                         1048576, 524288};
    if (i < 12) return tab[i];
    return longint'(1) << (30 - i);
  endfunction

  function automatic longint root_floor(longint unsigned v);
    longint unsigned r, bt;
    r = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= r + bt) begin
        v = v - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return longint'(r);
  endfunction

  function automatic longint vector_angle(longint x, longint y);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < CORDIC_N; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_q30(i);
      end else begin
        x -= dx; y += dy; z -= atan_q30(i);
      end
    end
    return z;
  endfunction

  function automatic longint rotate_sine(longint z);
    longint x, y, dx, dy;
    x = CORDIC_K;
    y = 0;
    for (int i = 0; i < CORDIC_N; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_q30(i);
      end else begin
        x += dx; y -= dy; z += atan_q30(i);
      end
    end
    return y;
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  function automatic res_t slerp_predict(slerp_req_t r);
    longint a [4];
    longint b [4];
    longint t, dot, k0, k1, c30, s30, w;
    longint unsigned cq;
    bit neg;
    res_t o;
    logic signed [15:0] q [4];
    neg = 1'b0;
    dot = 0;
    for (int j = 0; j < 4; j++) begin
      a[j] = longint'(r.a[j]);
      b[j] = longint'(r.b[j]);
    end
    t = longint'(r.blend);
    o.cos_omega = '0;
    o.cos_valid = 1'b0;
    o.b_negated = 1'b0;
    if (t <= 0 || t >= ONE_T) begin
      for (int j = 0; j < 4; j++) q[j] = (t <= 0) ? r.a[j] : r.b[j];
    end else begin
      for (int j = 0; j < 4; j++) dot += a[j] * b[j];
      if (dot < 0) begin
        neg = 1'b1;
        dot = -dot;
        for (int j = 0; j < 4; j++) b[j] = -b[j];
      end
      cq = longint'(dot >>> 15);
      if (cq > 32767) cq = 32767;
      if (cq > threshold) begin
        k0 = (ONE_T - t) * 16384;
        k1 = t * 16384;
        linear_hits++;
      end else begin
        c30 = longint'(cq << 15);
        s30 = root_floor((64'd1 << 60) - longint'(c30 * c30));
        w = vector_angle(c30, s30);
        if (w < 0) w = 0;
        k0 = rotate_sine((w * (ONE_T - t)) >>> 16) * (longint'(1) << 30) / s30;
        k1 = rotate_sine((w * t) >>> 16) * (longint'(1) << 30) / s30;
      end
      for (int j = 0; j < 4; j++)
        q[j] = clamp16((k0 * a[j] + k1 * b[j] + (longint'(1) << 29)) >>> 30);
      o.cos_omega = cq[14:0];
      o.cos_valid = 1'b1;
      o.b_negated = neg;
      if (neg) flips++;
    end
    o.x = q[0]; o.y = q[1]; o.z = q[2]; o.w = q[3];
    return o;
  endfunction

  // ---------------- request side ----------------
  task automatic send_request(slerp_req_t r);
    int gap;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      gap = int'($urandom_range(1, 10));
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.a_x <= r.a[0]; in_ch.a_y <= r.a[1]; in_ch.a_z <= r.a[2]; in_ch.a_w <= r.a[3];
    in_ch.b_x <= r.b[0]; in_ch.b_y <= r.b[1]; in_ch.b_z <= r.b[2]; in_ch.b_w <= r.b[3];
    in_ch.blend <= r.blend;
    do @(posedge clk); while (!in_ch.ready);
    blend_q.push_back(slerp_predict(r));
    sent++;
    @(negedge clk);
  endtask

  task automatic end_burst();
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    end_burst();
    while (blend_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    threshold = v;
    cfg_writes++;
  endtask

  function automatic slerp_req_t make_req(int ax, int ay, int az, int aw,
                                          int bx, int by, int bz, int bw, int t);
    slerp_req_t r;
    r.a[0] = 16'(ax); r.a[1] = 16'(ay); r.a[2] = 16'(az); r.a[3] = 16'(aw);
    r.b[0] = 16'(bx); r.b[1] = 16'(by); r.b[2] = 16'(bz); r.b[3] = 16'(bw);
    r.blend = 18'(t);
    return r;
  endfunction

  function automatic slerp_req_t random_req();
    slerp_req_t r;
    int mode;
    int d;
    mode = int'($urandom_range(0, 9));
    for (int j = 0; j < 4; j++) begin
      r.a[j] = 16'($urandom());
      r.b[j] = 16'($urandom());
    end
    // near-parallel and near-opposite pairs reach the high-cosine and linear paths
    if (mode < 4) begin
      for (int j = 0; j < 4; j++) begin
        d = int'(r.a[j]) + int'($urandom_range(0, 64)) - 32;
        if (d > 32767) d = 32767;
        if (d < -32768) d = -32768;
        r.b[j] = 16'((mode == 0 && d != -32768) ? -d : d);
      end
    end
    case ($urandom_range(0, 9))
      0:       r.blend = 18'($urandom());
      1:       r.blend = 18'(-int'($urandom_range(0, 131072)));
      2:       r.blend = 18'($urandom_range(65536, 131071));
      3:       r.blend = 18'($urandom_range(1, 8));
      4:       r.blend = 18'($urandom_range(65528, 65535));
      default: r.blend = 18'($urandom_range(1, 65535));
    endcase
    return r;
  endfunction

  // ---------------- result side ----------------
  always @(negedge clk) begin
    if (stall_on) begin
      out_ch.ready <= 1'b0;
    end else if (hold_req > 0) begin
      out_ch.ready <= 1'b0;
      hold_req <= hold_req - 1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      hold_req <= int'($urandom_range(0, 9));
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    res_t e;
    cycles <= cycles + 1;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (blend_q.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        e = blend_q.pop_front();
        checked++;
        if (out_ch.out_x !== e.x) begin
          $error("out_x expected %0d got %0d", e.x, out_ch.out_x); errors++;
        end
        if (out_ch.out_y !== e.y) begin
          $error("out_y expected %0d got %0d", e.y, out_ch.out_y); errors++;
        end
        if (out_ch.out_z !== e.z) begin
          $error("out_z expected %0d got %0d", e.z, out_ch.out_z); errors++;
        end
        if (out_ch.out_w !== e.w) begin
          $error("out_w expected %0d got %0d", e.w, out_ch.out_w); errors++;
        end
        if (out_ch.cos_omega !== e.cos_omega) begin
          $error("cos_omega expected %0d got %0d", e.cos_omega, out_ch.cos_omega);
          errors++;
        end
        if (out_ch.cos_valid !== e.cos_valid) begin
          $error("cos_valid expected %0d got %0d", e.cos_valid, out_ch.cos_valid);
          errors++;
        end
        if (out_ch.b_negated !== e.b_negated) begin
          $error("b_negated expected %0d got %0d", e.b_negated, out_ch.b_negated);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout with %0d results outstanding", blend_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------- tests ----------------
  task automatic test_directed();
    send_request(make_req(100, -200, 300, -400, 5, 6, 7, 8, 0));
    send_request(make_req(-32768, 32767, -32768, 32767, 1, 2, 3, 4, -131072));
    send_request(make_req(1, 2, 3, 4, -32768, 32767, 0, -1, 65536));
    send_request(make_req(1, 2, 3, 4, 32767, -32768, -1, 0, 131071));
    // orthogonal pair: zero dot, no flip
    send_request(make_req(32767, 0, 0, 0, 0, 32767, 0, 0, 32768));
    send_request(make_req(32767, 0, 0, 0, 0, -32768, 0, 0, 1));
    // opposite sign with -32768 components: flip overflows to +32768
    send_request(make_req(32767, 32767, 0, 0, -32768, -32768, 0, 0, 20000));
    // dot above one saturates the cosine
    send_request(make_req(-32768, -32768, -32768, -32768,
                          -32768, -32768, -32768, -32768, 40000));
    send_request(make_req(32767, 32767, 32767, 32767,
                          32767, 32767, 32767, 32767, 65535));
    send_request(make_req(16384, 16384, 16384, 16384,
                          16384, 16384, 16384, 16383, 32768));
    send_request(make_req(23170, 23170, 0, 0, 23170, 0, 23170, 0, 1));
    send_request(make_req(23170, 23170, 0, 0, 0, -23170, -23170, 0, 65535));
    send_request(make_req(0, 0, 0, 0, 0, 0, 0, 0, 30000));
    send_request(make_req(-1, -1, -1, -1, 1, 1, 1, 1, 50000));
    wait_drained();
  endtask

  task automatic test_threshold(logic [THR_W-1:0] v, int n);
    write_threshold(v);
    for (int i = 0; i < n; i++) send_request(random_req());
    wait_drained();
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_request(random_req());
    wait_drained();
  endtask

  task automatic test_full_pipe(int n);
    // hold the receiver off in its own process while requests keep coming
    fork
      begin
        stall_on = 1'b1;
        repeat (STALL_CYCLES) @(posedge clk);
        stall_on = 1'b0;
      end
    join_none
    for (int i = 0; i < n; i++) send_request(random_req());
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    idle_en = 1'b1;
    test_threshold(15'd0, 60);
    test_threshold(15'd32767, 80);
    test_threshold(15'd32700, 60);
    test_threshold(15'($urandom_range(1, 32766)), 60);
    test_threshold(THR_RESET, 100);
    test_full_pipe(200);
    idle_en = 1'b0;
    test_random(60);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d requests, %0d results checked, %0d threshold writes",
             sent, checked, cfg_writes);
    $display("%0d linear blends, %0d flipped second quaternions", linear_hits, flips);
    if (errors == 0 && blend_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/qs_pkg.sv
rtl/qs_if.sv
rtl/qs_isqrt.sv
rtl/qs_cordic_vec.sv
rtl/qs_weight_lane.sv
rtl/qs_blend_lane.sv
rtl/quaternion_slerp.sv
tb/tb_top.sv
